/* rtl/core/spc_pkg.sv */
// shared types and constants for the servo pulse controller
`timescale 1ns / 1ps

package spc_pkg;

  // servo geometry and pwm frame
  localparam logic [7:0]  ANGLE_FULL  = 8'd180;
  localparam logic [15:0] FRAME_US    = 16'd20000;

  // reset values
  localparam logic [15:0] PULSE_MIN_RST = 16'd1000;
  localparam logic [15:0] PULSE_MAX_RST = 16'd2000;
  localparam logic [15:0] PERIOD_RST    = 16'd20000;
  localparam logic [7:0]  ANGLE_RST     = 8'd90;
  localparam logic [15:0] PULSE_RST     = 16'd1500;

  // command codes
  localparam logic [2:0] ACT_ANGLE  = 3'd0;
  localparam logic [2:0] ACT_PULSE  = 3'd1;
  localparam logic [2:0] ACT_SWEEP  = 3'd2;
  localparam logic [2:0] ACT_ATTACH = 3'd3;
  localparam logic [2:0] ACT_DETACH = 3'd4;
  localparam logic [2:0] ACT_TICK   = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] value;
    logic [15:0] step_ms;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_cmp;
    logic        duty_update;
    logic        pwm_enable;
    logic [7:0]  angle_now;
    logic [15:0] pulse_now;
    logic        sweeping;
  } out_t;

endpackage

/* rtl/core/servo_pulse_controller.sv */
// top level of the servo pulse controller with its shared multiply and divide unit
`timescale 1ns / 1ps

// Servo pulse controller. Each command (write angle, write microseconds, sweep,
// attach, detach, millisecond tick) returns one result with the PWM compare value,
// the load strobe, the attached flag, the current angle and pulse, and the sweep
// flag. All multiplies and divides run on one shared unit: a 16x16 multiplier
// whose product is registered into a restoring divider that retires one
// quotient bit per cycle. A command that only recomputes the duty makes one
// pass through the unit; one that also moves the angle or pulse (write angle,
// write microseconds, a sweep step) makes two passes, position first and then
// duty. The sequencer returns to idle when the result enters the output register.
// in_ready is high only while the sequencer is idle; a finished result waits in
// an output register, so the next command can be accepted before the last
// result is taken.
// Configuration writes take effect at once and are meant for idle periods only.
module servo_pulse_controller
  import spc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic PH_POS  = 1'b0;
  localparam logic PH_DUTY = 1'b1;

  // configuration
  logic [15:0] pulse_min_r, pulse_max_r, period_r;

  // servo state
  logic [7:0]  cur_angle_r, cur_angle_nxt;
  logic [15:0] cur_pulse_r, cur_pulse_nxt;
  logic        attached_r, attached_nxt;
  logic [7:0]  sweep_target_r, sweep_target_nxt;
  logic        sweep_active_r, sweep_active_nxt;
  logic [15:0] sweep_reload_r, sweep_reload_nxt;
  logic [15:0] sweep_wait_r, sweep_wait_nxt;
  logic        apply_r, apply_nxt;

  // sequencer
  logic [1:0]  state_r, state_nxt;
  logic        phase_r, phase_nxt;
  logic        from_pulse_r, from_pulse_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  // shared unit datapath
  logic [31:0] dvd_r, dvd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] div_r, div_nxt;
  logic [15:0] duty_r, duty_nxt;

  // output register
  out_t        out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  // combinational helpers
  logic [15:0] range_w;
  logic [7:0]  ang_clamp;
  logic [15:0] pulse_clamp;
  logic [7:0]  sw_tgt;
  logic [7:0]  step_ang;
  logic [15:0] step_ld;
  logic [15:0] mul_a, mul_b, mul_d;
  logic [31:0] prod;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        q_bit;
  logic [31:0] quo;

  assign range_w = pulse_max_r - pulse_min_r;

  // clamp the command value as an angle and as a pulse
  assign ang_clamp = (in_data.value > {8'd0, ANGLE_FULL}) ? ANGLE_FULL : in_data.value[7:0];
  always_comb begin
    if (in_data.value < pulse_min_r) begin
      pulse_clamp = pulse_min_r;
    end else if (in_data.value > pulse_max_r) begin
      pulse_clamp = pulse_max_r;
    end else begin
      pulse_clamp = in_data.value;
    end
  end

  // one degree toward the sweep target
  assign sw_tgt   = (in_data.action == ACT_SWEEP) ? ang_clamp : sweep_target_r;
  assign step_ang = (cur_angle_r < sw_tgt) ? cur_angle_r + 8'd1 : cur_angle_r - 8'd1;
  assign step_ld  = (in_data.step_ms == 16'd0) ? 16'd1 : in_data.step_ms;

  // operand select for the shared multiply and divide
  always_comb begin
    if (phase_r == PH_DUTY) begin
      mul_a = cur_pulse_r;
      mul_b = period_r;
      mul_d = FRAME_US;
    end else if (from_pulse_r) begin
      mul_a = cur_pulse_r - pulse_min_r;
      mul_b = {8'd0, ANGLE_FULL};
      mul_d = range_w;
    end else begin
      mul_a = range_w;
      mul_b = {8'd0, cur_angle_r};
      mul_d = {8'd0, ANGLE_FULL};
    end
  end

  assign prod = mul_a * mul_b;

  // restoring divide step, one quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[31]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign q_bit   = (rem_sh >= {1'b0, div_r});
  assign quo     = {dvd_r[30:0], q_bit};

  // sequencer and state update
  always_comb begin
    cur_angle_nxt    = cur_angle_r;
    cur_pulse_nxt    = cur_pulse_r;
    attached_nxt     = attached_r;
    sweep_target_nxt = sweep_target_r;
    sweep_active_nxt = sweep_active_r;
    sweep_reload_nxt = sweep_reload_r;
    sweep_wait_nxt   = sweep_wait_r;
    apply_nxt        = apply_r;
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    from_pulse_nxt   = from_pulse_r;
    cnt_nxt          = cnt_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    div_nxt          = div_r;
    duty_nxt         = duty_r;
    out_data_nxt     = out_data_r;
    out_valid_nxt    = out_valid_r;
    in_ready         = (state_r == ST_IDLE);

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          apply_nxt      = 1'b0;
          phase_nxt      = PH_DUTY;
          from_pulse_nxt = 1'b0;
          case (in_data.action)
            ACT_ANGLE: begin
              sweep_active_nxt = 1'b0;
              cur_angle_nxt    = ang_clamp;
              apply_nxt        = 1'b1;
              phase_nxt        = PH_POS;
            end
            ACT_PULSE: begin
              sweep_active_nxt = 1'b0;
              cur_pulse_nxt    = pulse_clamp;
              apply_nxt        = 1'b1;
              phase_nxt        = PH_POS;
              from_pulse_nxt   = 1'b1;
            end
            ACT_SWEEP: begin
              if (!attached_r) begin
                apply_nxt = 1'b1;
              end
              attached_nxt     = 1'b1;
              sweep_target_nxt = ang_clamp;
              sweep_active_nxt = 1'b0;
              if (cur_angle_r != ang_clamp) begin
                sweep_active_nxt = (step_ang != ang_clamp);
                sweep_reload_nxt = step_ld;
                sweep_wait_nxt   = step_ld;
                cur_angle_nxt    = step_ang;
                apply_nxt        = 1'b1;
                phase_nxt        = PH_POS;
              end
            end
            ACT_ATTACH: begin
              attached_nxt = 1'b1;
              apply_nxt    = 1'b1;
            end
            ACT_DETACH: begin
              attached_nxt     = 1'b0;
              sweep_active_nxt = 1'b0;
            end
            ACT_TICK: begin
              if (sweep_active_r) begin
                if (sweep_wait_r > 16'd1) begin
                  sweep_wait_nxt = sweep_wait_r - 16'd1;
                end else begin
                  sweep_wait_nxt   = sweep_reload_r;
                  cur_angle_nxt    = step_ang;
                  sweep_active_nxt = (step_ang != sweep_target_r);
                  apply_nxt        = 1'b1;
                  phase_nxt        = PH_POS;
                end
              end
            end
            default: begin
            end
          endcase
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        dvd_nxt   = prod;
        rem_nxt   = 16'd0;
        div_nxt   = mul_d;
        cnt_nxt   = 5'd0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = q_bit ? rem_sub[15:0] : rem_sh[15:0];
        dvd_nxt = quo;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          if (phase_r == PH_POS) begin
            if (from_pulse_r) begin
              cur_angle_nxt = (range_w == 16'd0) ? 8'd0 : quo[7:0];
            end else begin
              cur_pulse_nxt = pulse_min_r + quo[15:0];
            end
            phase_nxt = PH_DUTY;
            state_nxt = ST_MUL;
          end else begin
            duty_nxt  = (quo > {16'd0, period_r}) ? period_r : quo[15:0];
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.duty_cmp    = duty_r;
          out_data_nxt.duty_update = apply_r && attached_r;
          out_data_nxt.pwm_enable  = attached_r;
          out_data_nxt.angle_now   = cur_angle_r;
          out_data_nxt.pulse_now   = cur_pulse_r;
          out_data_nxt.sweeping    = sweep_active_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration registers, range writes keep min below max
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r <= PULSE_MIN_RST;
      pulse_max_r <= PULSE_MAX_RST;
      period_r    <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_MIN: begin
          if (cfg_wdata < pulse_max_r) begin
            pulse_min_r <= cfg_wdata;
          end
        end
        REG_PULSE_MAX: begin
          if (pulse_min_r < cfg_wdata) begin
            pulse_max_r <= cfg_wdata;
          end
        end
        REG_PERIOD: begin
          period_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // control and servo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_angle_r    <= ANGLE_RST;
      cur_pulse_r    <= PULSE_RST;
      attached_r     <= 1'b0;
      sweep_target_r <= 8'd0;
      sweep_active_r <= 1'b0;
      sweep_reload_r <= 16'd0;
      sweep_wait_r   <= 16'd0;
      apply_r        <= 1'b0;
      state_r        <= ST_IDLE;
      phase_r        <= PH_DUTY;
      from_pulse_r   <= 1'b0;
      cnt_r          <= 5'd0;
      out_valid_r    <= 1'b0;
    end else begin
      cur_angle_r    <= cur_angle_nxt;
      cur_pulse_r    <= cur_pulse_nxt;
      attached_r     <= attached_nxt;
      sweep_target_r <= sweep_target_nxt;
      sweep_active_r <= sweep_active_nxt;
      sweep_reload_r <= sweep_reload_nxt;
      sweep_wait_r   <= sweep_wait_nxt;
      apply_r        <= apply_nxt;
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      from_pulse_r   <= from_pulse_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    duty_r     <= duty_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/spc_checker.sv */
// port-level checker for the servo pulse controller and its bind
`timescale 1ns / 1ps

module spc_checker
  import spc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_t                 out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the block is busy in the cycle after each accepted transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction");

  // a duty load only goes to a running pwm
  a_load_attached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.duty_update |-> out_data.pwm_enable)
    else $error("duty load while detached");

  // a sweep in progress implies attached; every result has its angle in range
  a_sweep_attached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sweeping |-> out_data.pwm_enable)
    else $error("sweeping while detached");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.angle_now <= ANGLE_FULL)
    else $error("angle beyond full scale");

endmodule

bind servo_pulse_controller spc_checker u_spc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/tb.sv */
// self-checking testbench for the servo pulse controller: directed table then random command streams
`timescale 1ns / 1ps

module tb;
  import spc_pkg::*;

  // codes the block must ignore
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 5000000;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned NUM_PHASES    = 6;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  servo_pulse_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the servo state and registers
  logic [15:0] p_min, p_max, p_period;
  logic [7:0]  s_angle, s_target;
  logic [15:0] s_pulse, s_reload, s_wait;
  bit          s_attached, s_sweeping;

  // predicted status of every accepted command, oldest first
  out_t status_q[$];

  typedef struct {
    in_t  cmd;
    bit   typed;
    out_t want;
  } dir_row_t;
  dir_row_t dir_rows[$];

  logic [2:0] act_codes[6] = '{ACT_ANGLE, ACT_PULSE, ACT_SWEEP, ACT_ATTACH, ACT_DETACH, ACT_TICK};

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("servo_pulse_controller regression: fail");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic void reset_servo_model();
    p_min      = PULSE_MIN_RST;
    p_max      = PULSE_MAX_RST;
    p_period   = PERIOD_RST;
    s_angle    = ANGLE_RST;
    s_pulse    = PULSE_RST;
    s_attached = 1'b0;
    s_target   = '0;
    s_sweeping = 1'b0;
    s_reload   = '0;
    s_wait     = '0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    case (idx)
      REG_PULSE_MIN: if (v < p_max) p_min = v;
      REG_PULSE_MAX: if (p_min < v) p_max = v;
      REG_PERIOD:    p_period = v;
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] duty_for(logic [15:0] pulse);
    logic [31:0] d;
    d = (32'(pulse) * 32'(p_period)) / 32'(FRAME_US);
    if (d > 32'(p_period)) d = 32'(p_period);
    return d[15:0];
  endfunction

  function automatic void move_to_angle(logic [31:0] a);
    logic [31:0] span, p;
    span = 32'(p_max) - 32'(p_min);
    if (a > 32'(ANGLE_FULL)) a = 32'(ANGLE_FULL);
    s_angle = a[7:0];
    p = 32'(p_min) + (span * a) / 32'(ANGLE_FULL);
    s_pulse = p[15:0];
  endfunction

  function automatic void move_to_pulse(logic [31:0] p);
    logic [31:0] span, a;
    if (p < 32'(p_min)) p = 32'(p_min);
    if (p > 32'(p_max)) p = 32'(p_max);
    span = 32'(p_max) - 32'(p_min);
    s_pulse = p[15:0];
    a = (span != 0) ? ((p - 32'(p_min)) * 32'(ANGLE_FULL)) / span : 32'd0;
    s_angle = a[7:0];
  endfunction

  function automatic void step_sweep();
    if (s_angle < s_target) move_to_angle(32'(s_angle) + 32'd1);
    else if (s_angle > s_target) move_to_angle(32'(s_angle) - 32'd1);
    if (s_angle == s_target) s_sweeping = 1'b0;
  endfunction

  function automatic out_t predict_servo(in_t cmd);
    out_t       r;
    bit         load;
    logic [7:0] tgt;
    load = 1'b0;
    case (cmd.action)
      ACT_ANGLE: begin
        s_sweeping = 1'b0;
        move_to_angle(32'(cmd.value));
        load = 1'b1;
      end
      ACT_PULSE: begin
        s_sweeping = 1'b0;
        move_to_pulse(32'(cmd.value));
        load = 1'b1;
      end
      ACT_SWEEP: begin
        tgt = (cmd.value > 16'(ANGLE_FULL)) ? ANGLE_FULL : cmd.value[7:0];
        if (!s_attached) begin
          s_attached = 1'b1;
          load = 1'b1;
        end
        s_target = tgt;
        s_sweeping = 1'b0;
        if (s_angle != tgt) begin
          s_sweeping = 1'b1;
          s_reload = (cmd.step_ms != 16'd0) ? cmd.step_ms : 16'd1;
          s_wait = s_reload;
          step_sweep();
          load = 1'b1;
        end
      end
      ACT_ATTACH: begin
        s_attached = 1'b1;
        load = 1'b1;
      end
      ACT_DETACH: begin
        s_attached = 1'b0;
        s_sweeping = 1'b0;
      end
      ACT_TICK: begin
        if (s_sweeping) begin
          if (s_wait > 16'd1) begin
            s_wait = s_wait - 16'd1;
          end else begin
            s_wait = s_reload;
            step_sweep();
            load = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.duty_cmp    = duty_for(s_pulse);
    r.duty_update = load && s_attached;
    r.pwm_enable  = s_attached;
    r.angle_now   = s_angle;
    r.pulse_now   = s_pulse;
    r.sweeping    = s_sweeping;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [15:0] rand_angle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 16'($urandom_range(0, 180));
    if (pick < 85) return 16'($urandom_range(181, 255));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_pulse();
    if ($urandom_range(0, 99) < 60) return 16'($urandom_range(p_max, p_min));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_step();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 16'($urandom_range(0, 2));
    if (pick < 85) return 16'($urandom_range(3, 10));
    return 16'($urandom);
  endfunction

  function automatic in_t rand_cmd();
    in_t c;
    if ($urandom_range(0, 99) < 6)
      c.action = ($urandom_range(0, 1) != 0) ? ACT_UNUSED_7 : ACT_UNUSED_6;
    else
      c.action = act_codes[$urandom_range(0, 5)];
    case (c.action)
      ACT_ANGLE, ACT_SWEEP: c.value = rand_angle();
      ACT_PULSE:            c.value = rand_pulse();
      default:              c.value = 16'($urandom);
    endcase
    c.step_ms = (c.action == ACT_SWEEP) ? rand_step() : 16'($urandom);
    return c;
  endfunction

  // one command transaction, with bursty gaps on the sender side
  task automatic issue(input in_t cmd, input bit typed, input out_t want, output bit counted);
    int unsigned gap;
    out_t        pred;
    counted = (cmd.action <= ACT_TICK) && !(cmd.action == ACT_TICK && !s_sweeping);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    pred = predict_servo(cmd);
    status_q.push_back(typed ? want : pred);
  endtask

  // stop sending and let every pending result drain
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    apply_reg_write(idx, v);
  endtask

  // move the pulse window and period, with two rejected range writes
  task automatic set_range(input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] per);
    write_reg(REG_PULSE_MAX, 16'hFFFF);
    write_reg(REG_PULSE_MIN, lo);
    write_reg(REG_PULSE_MAX, hi);
    write_reg(REG_PERIOD, per);
    write_reg(REG_PULSE_MIN, hi);
    write_reg(REG_PULSE_MAX, lo);
    write_reg(REG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input in_t cmd, input bit typed, input out_t want);
    dir_row_t r;
    r.cmd   = cmd;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  // mostly sweeps followed by ticks, with stray commands mixed in
  task automatic run_random_phase(input int unsigned quota);
    int unsigned done_cnt, n;
    bit          c;
    in_t         cmd;
    done_cnt = 0;
    while (done_cnt < quota) begin
      if ($urandom_range(0, 99) < 55) begin
        cmd.action  = ACT_SWEEP;
        cmd.value   = rand_angle();
        cmd.step_ms = rand_step();
        issue(cmd, 1'b0, '0, c);
        done_cnt += c;
        n = $urandom_range(1, 100);
        repeat (n) begin
          if ($urandom_range(0, 99) < 6) begin
            cmd = rand_cmd();
          end else begin
            cmd.action  = ACT_TICK;
            cmd.value   = 16'($urandom);
            cmd.step_ms = 16'($urandom);
          end
          issue(cmd, 1'b0, '0, c);
          done_cnt += c;
        end
      end else begin
        cmd = rand_cmd();
        issue(cmd, 1'b0, '0, c);
        done_cnt += c;
      end
    end
  endtask

  // ---------------- receiver ----------------

  initial begin
    int unsigned mode, seg, k;
    bit          held;
    out_ready = 1'b0;
    held = 1'b0;
    k = 0;
    wait (rst_n);
    forever begin
      if (hold_req && !held) begin
        // long hold-off so the block backs up and stalls its input
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(50, 400);
      repeat (seg) begin
        @(negedge clk);
        k++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) != 0);
          2: out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= ((k % 150) >= 120);
        endcase
      end
    end
  end

  // ---------------- result checking ----------------

  task automatic report_field(input string name, input int unsigned want, input int unsigned got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected: actual %h", $time, out_data);
        errors++;
      end else begin
        want = status_q.pop_front();
        if (out_data.duty_cmp !== want.duty_cmp)
          report_field("duty_cmp", want.duty_cmp, out_data.duty_cmp);
        if (out_data.duty_update !== want.duty_update)
          report_field("duty_update", want.duty_update, out_data.duty_update);
        if (out_data.pwm_enable !== want.pwm_enable)
          report_field("pwm_enable", want.pwm_enable, out_data.pwm_enable);
        if (out_data.angle_now !== want.angle_now)
          report_field("angle_now", want.angle_now, out_data.angle_now);
        if (out_data.pulse_now !== want.pulse_now)
          report_field("pulse_now", want.pulse_now, out_data.pulse_now);
        if (out_data.sweeping !== want.sweeping)
          report_field("sweeping", want.sweeping, out_data.sweeping);
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    bit          c;
    logic [15:0] lo, hi;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reset_servo_model();

    // directed table, reset values in effect
    add_row('{ACT_TICK, 16'd0, 16'd0}, 1, '{16'd1500, 1'b0, 1'b0, 8'd90, 16'd1500, 1'b0});
    add_row('{ACT_DETACH, 16'd0, 16'd0}, 1, '{16'd1500, 1'b0, 1'b0, 8'd90, 16'd1500, 1'b0});
    add_row('{ACT_ANGLE, 16'd180, 16'd0}, 1, '{16'd2000, 1'b0, 1'b0, 8'd180, 16'd2000, 1'b0});
    add_row('{ACT_ATTACH, 16'd0, 16'd0}, 1, '{16'd2000, 1'b1, 1'b1, 8'd180, 16'd2000, 1'b0});
    add_row('{ACT_ANGLE, 16'hFFFF, 16'hFFFF}, 1,
            '{16'd2000, 1'b1, 1'b1, 8'd180, 16'd2000, 1'b0});
    add_row('{ACT_ANGLE, 16'd0, 16'd0}, 1, '{16'd1000, 1'b1, 1'b1, 8'd0, 16'd1000, 1'b0});
    add_row('{ACT_PULSE, 16'hFFFF, 16'd0}, 1, '{16'd2000, 1'b1, 1'b1, 8'd180, 16'd2000, 1'b0});
    add_row('{ACT_PULSE, 16'd0, 16'd0}, 1, '{16'd1000, 1'b1, 1'b1, 8'd0, 16'd1000, 1'b0});
    add_row('{ACT_PULSE, 16'd1500, 16'd0}, 1, '{16'd1500, 1'b1, 1'b1, 8'd90, 16'd1500, 1'b0});
    add_row('{ACT_UNUSED_6, 16'hFFFF, 16'hFFFF}, 1,
            '{16'd1500, 1'b0, 1'b1, 8'd90, 16'd1500, 1'b0});
    add_row('{ACT_UNUSED_7, 16'hFFFF, 16'hFFFF}, 1,
            '{16'd1500, 1'b0, 1'b1, 8'd90, 16'd1500, 1'b0});
    add_row('{ACT_ATTACH, 16'd0, 16'd0}, 1, '{16'd1500, 1'b1, 1'b1, 8'd90, 16'd1500, 1'b0});
    add_row('{ACT_SWEEP, 16'd90, 16'd5}, 1, '{16'd1500, 1'b0, 1'b1, 8'd90, 16'd1500, 1'b0});
    add_row('{ACT_SWEEP, 16'd92, 16'd0}, 0, '0);
    add_row('{ACT_TICK, 16'd0, 16'd0}, 0, '0);
    add_row('{ACT_TICK, 16'd0, 16'd0}, 0, '0);
    add_row('{ACT_SWEEP, 16'hFFFF, 16'd2}, 0, '0);
    add_row('{ACT_TICK, 16'd0, 16'd0}, 0, '0);
    add_row('{ACT_TICK, 16'd0, 16'd0}, 0, '0);
    add_row('{ACT_TICK, 16'd0, 16'd0}, 0, '0);
    add_row('{ACT_ANGLE, 16'd45, 16'd0}, 0, '0);
    add_row('{ACT_TICK, 16'd0, 16'd0}, 0, '0);
    add_row('{ACT_SWEEP, 16'd0, 16'hFFFF}, 0, '0);
    add_row('{ACT_DETACH, 16'd0, 16'd0}, 0, '0);
    add_row('{ACT_SWEEP, 16'd10, 16'd1}, 0, '0);
    add_row('{ACT_TICK, 16'd0, 16'd0}, 0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) issue(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want, c);

    // random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: ;
        1: set_range(16'd0, 16'hFFFF, 16'hFFFF);
        2: set_range(16'hFFFE, 16'hFFFF, 16'd0);
        3: set_range(16'd0, 16'd1, 16'd1);
        4: set_range(16'd500, 16'd2500, 16'd20000);
        default: begin
          lo = 16'($urandom_range(0, 65000));
          hi = 16'($urandom_range(65535, lo + 1));
          set_range(lo, hi, 16'($urandom));
        end
      endcase
      if (ph == 1) hold_req = 1'b1;
      run_random_phase(PHASE_ITEMS);
    end

    drain();
    if (status_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, status_q.size());
      errors++;
    end
    if (errors == 0)
      $display("servo_pulse_controller regression: pass");
    else
      $display("servo_pulse_controller regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/core/spc_pkg.sv
rtl/core/servo_pulse_controller.sv
rtl/core/spc_checker.sv
test/tb.sv
